@@ hdl/hrvtd_pkg.sv @@
// shared types, codes and constants for the hrv time-domain metrics block
package hrvtd_pkg;

	localparam int WINDOW_DEPTH_DEF  = 256;
	localparam int PENDING_DEPTH_DEF = 64;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 13;

	localparam logic [CFG_IW-1:0] CFG_MIN_BEATS     = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_INTERVAL_LOW  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_INTERVAL_HIGH = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_OUTLIER_PCT   = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_SUCC_LIMIT    = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_MOTION_LIMIT  = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_QUALITY_LIMIT = 3'd6;

	localparam logic REQ_BEAT   = 1'b0;
	localparam logic REQ_UPDATE = 1'b1;

	localparam logic [1:0] STATUS_IDLE        = 2'd0;
	localparam logic [1:0] STATUS_ACQUIRING   = 2'd1;
	localparam logic [1:0] STATUS_LOW_QUALITY = 2'd2;
	localparam logic [1:0] STATUS_VALID       = 2'd3;

	localparam int ACC_ONE_G         = 4096;
	localparam int MOTION_CAP        = 4096;
	localparam int METRIC_CAP        = 4800;
	localparam int PNN_CAP           = 1600;
	localparam int PNN_SCALE         = 1600;
	localparam int OUTLIER_MIN_COUNT = 5;
	localparam int Q_BEATS_OFFS      = 30;
	localparam int Q_BEATS_CAP       = 90;
	localparam int Q_UPQ_OFFS        = 3072;
	localparam int Q_UPQ_CAP         = 5120;
	localparam int Q_MOTION_REF      = 2048;
	localparam int Q_W_UPQ           = 54;
	localparam int Q_W_MOTION        = 135;
	localparam int Q_DIVISOR         = 900;

	typedef struct packed {
		logic        req_type;
		logic [11:0] interval_ms;
		logic [15:0] accel_magnitude;
		logic [10:0] upstream_quality;
		logic        upstream_idle;
		logic [31:0] time_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] rmssd;
		logic [12:0] sdnn;
		logic [10:0] pnn50;
		logic [10:0] quality;
		logic        result_valid;
		logic [31:0] stamp_ms;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_P_RD,
		ST_P_DATA,
		ST_MED_SCAN,
		ST_MED_STEP,
		ST_OUTLIER,
		ST_PUSH,
		ST_CHECK_N,
		ST_STAT_SCAN,
		ST_M_NQ,
		ST_M_SS,
		ST_M_SUB,
		ST_SD_LOAD,
		ST_SD_DIV,
		ST_SD_SQL,
		ST_SD_SQRT,
		ST_RM_LOAD,
		ST_RM_DIV,
		ST_RM_SQL,
		ST_RM_SQRT,
		ST_PN_MUL,
		ST_PN_LOAD,
		ST_PN_DIV,
		ST_Q_LOAD,
		ST_Q_DIV,
		ST_FINISH,
		ST_EMIT
	} state_t;

endpackage

@@ hdl/hrv_time_domain_metrics.sv @@
// hrv time-domain metrics: beat queue, filtered window, sdnn/rmssd/pnn50 and quality
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | hrvtd_pkg::req_t
//  res     | out       | res_valid/res_stall | hrvtd_pkg::res_t
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// a beat is just queued; an update with no queued beats goes straight to its emit step
// each queued beat is read and range-checked, then median-tested in 24 window passes once n > 5
// metrics then take one window pass, 4 restoring divides of 2*W+32 steps and 2 root extractions
// (W = clog2(WINDOW_DEPTH + 1)); the shared divider and the single window read port set the pace
// reset clears counters and heads, sets held result to acquiring; stores need no clearing pass
// a result waits in the output register; the block holds in its emit step while that is full
module hrv_time_domain_metrics #(
	parameter int WINDOW_DEPTH  = hrvtd_pkg::WINDOW_DEPTH_DEF,
	parameter int PENDING_DEPTH = hrvtd_pkg::PENDING_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  hrvtd_pkg::req_t               req,
	output logic                          res_valid,
	input  logic                          res_stall,
	output hrvtd_pkg::res_t               res,
	input  logic                          cfg_we,
	input  logic [hrvtd_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [hrvtd_pkg::CFG_DW-1:0]  cfg_data
);

	localparam int WA   = $clog2(WINDOW_DEPTH);
	localparam int WC   = $clog2(WINDOW_DEPTH + 1);
	localparam int PA   = $clog2(PENDING_DEPTH);
	localparam int PC   = $clog2(PENDING_DEPTH + 1);
	localparam int SW   = 12 + WC;
	localparam int QW   = 24 + WC;
	localparam int MPW  = QW + SW;
	localparam int NUMW = WC + QW + 8;
	localparam int DENW = 2 * WC;
	localparam int RTW  = NUMW / 2;
	localparam int STW  = $clog2(NUMW);
	localparam int NCW  = (WC > 9) ? WC : 9;

	hrvtd_pkg::state_t state_q, state_d;

	// configuration
	logic [8:0]  min_beats_q;
	logic [11:0] int_low_q, int_high_q;
	logic [6:0]  outl_pct_q;
	logic [9:0]  succ_lim_q;
	logic [12:0] mot_lim_q;
	logic [10:0] qual_lim_q;

	// stores
	logic [11:0] pend_mem [PENDING_DEPTH];
	logic [11:0] win_mem [WINDOW_DEPTH];
	logic [11:0] pend_rd_q, win_rd_q;
	logic [PA-1:0] pend_head_q;
	logic [PC-1:0] pend_cnt_q;
	logic [WA-1:0] win_head_q;
	logic [WC-1:0] win_cnt_q;

	logic [12:0] motion_q;
	logic [10:0] upq_q;
	logic [31:0] stamp_in_q;
	hrvtd_pkg::res_t held_q, res_q;
	logic res_valid_q;

	// window scan
	logic [WC-1:0] scan_i_q;
	logic          rd_vld_s1;
	logic          scan_st, scan_issue, scan_done;
	logic [WA:0]   scan_sum, push_sum;
	logic [WA-1:0] scan_addr, push_addr;

	// median search
	logic [11:0]   cand_q, med_r_q, med_r1_q, med_tv, med_r_new;
	logic [3:0]    med_b_q;
	logic          med_pass_q;
	logic [WC-1:0] rank_q, med_cnt_q;
	logic [12:0]   m2_q, out_v2, out_dev;
	logic [19:0]   out_lhs, out_rhs;
	logic          out_reject;

	// statistics
	logic [SW-1:0] sum_q;
	logic [QW-1:0] sq_q, ssd_q;
	logic [WC-1:0] nn50_q;
	logic [11:0]   prev_q, st_df;
	logic          first_q;
	logic [23:0]   st_xsq, st_dfsq;

	// shared multiplier
	logic [QW-1:0]  mul_a;
	logic [SW-1:0]  mul_b;
	logic [MPW-1:0] mult_q, nq_q;

	// shared divider and root unit
	logic [NUMW-1:0] div_num_q;
	logic [DENW-1:0] div_den_q, div_rem_q;
	logic [DENW:0]   div_sh, div_sub;
	logic            div_ge, div_last;
	logic [NUMW-1:0] sq_op_q;
	logic [RTW-1:0]  sq_root_q;
	logic [RTW+1:0]  sq_rem_q, sq_sh, sq_trial;
	logic            sq_ge, sq_last;
	logic [STW-1:0]  step_q;
	logic [12:0]     root_sat;

	logic [12:0] sd_res_q, rm_res_q;
	logic [10:0] pn_res_q;

	// input side
	logic        acc_in, is_beat, in_range, short_win;
	logic [15:0] mot_d;
	logic [14:0] mot_lvl;
	logic [12:0] mot_new;
	logic [PA:0] pend_sum;
	logic [PA-1:0] pend_wa, pend_head_inc;
	logic [8:0]  need;
	hrvtd_pkg::state_t next_beat_st;

	// quality numerator
	logic [WC-1:0] n_m30;
	logic [6:0]    q_a;
	logic [13:0]   upq10;
	logic [12:0]   q_b;
	logic [11:0]   q_c;
	logic [19:0]   q_num;

	assign acc_in  = req_valid && !req_stall;
	assign is_beat = (req.req_type == hrvtd_pkg::REQ_BEAT);

	assign mot_d   = (req.accel_magnitude >= 16'(hrvtd_pkg::ACC_ONE_G)) ?
		req.accel_magnitude - 16'(hrvtd_pkg::ACC_ONE_G) :
		16'(hrvtd_pkg::ACC_ONE_G) - req.accel_magnitude;
	assign mot_lvl = mot_d[15:1];
	assign mot_new = (mot_lvl > 15'(hrvtd_pkg::MOTION_CAP)) ?
		13'(hrvtd_pkg::MOTION_CAP) : mot_lvl[12:0];

	assign pend_sum = (PA+1)'(pend_head_q) + (PA+1)'(pend_cnt_q);
	assign pend_wa  = (pend_cnt_q == PC'(PENDING_DEPTH)) ? pend_head_q :
		((pend_sum >= (PA+1)'(PENDING_DEPTH)) ? PA'(pend_sum - (PA+1)'(PENDING_DEPTH)) :
		pend_sum[PA-1:0]);
	assign pend_head_inc = (pend_head_q == PA'(PENDING_DEPTH - 1)) ? '0 : pend_head_q + 1'b1;

	assign in_range     = (pend_rd_q >= int_low_q) && (pend_rd_q <= int_high_q);
	assign next_beat_st = (pend_cnt_q == '0) ? hrvtd_pkg::ST_CHECK_N : hrvtd_pkg::ST_P_RD;
	assign need         = (min_beats_q < 9'd2) ? 9'd2 : min_beats_q;
	assign short_win    = NCW'(win_cnt_q) < NCW'(need);

	assign scan_st    = (state_q == hrvtd_pkg::ST_MED_SCAN) || (state_q == hrvtd_pkg::ST_STAT_SCAN);
	assign scan_issue = scan_st && (scan_i_q != win_cnt_q);
	assign scan_done  = scan_st && (scan_i_q == win_cnt_q) && !rd_vld_s1;
	assign scan_sum   = (WA+1)'(win_head_q) + (WA+1)'(scan_i_q);
	assign scan_addr  = (scan_sum >= (WA+1)'(WINDOW_DEPTH)) ?
		WA'(scan_sum - (WA+1)'(WINDOW_DEPTH)) : scan_sum[WA-1:0];
	assign push_sum   = (WA+1)'(win_head_q) + (WA+1)'(win_cnt_q);
	assign push_addr  = (win_cnt_q == WC'(WINDOW_DEPTH)) ? win_head_q :
		((push_sum >= (WA+1)'(WINDOW_DEPTH)) ? WA'(push_sum - (WA+1)'(WINDOW_DEPTH)) :
		push_sum[WA-1:0]);

	// test value for the current median bit: prefix with all lower bits set
	assign med_tv    = med_r_q | ((12'd1 << med_b_q) - 12'd1);
	assign med_r_new = (med_cnt_q <= rank_q) ? (med_r_q | (12'd1 << med_b_q)) : med_r_q;

	assign out_v2     = {cand_q, 1'b0};
	assign out_dev    = (out_v2 >= m2_q) ? out_v2 - m2_q : m2_q - out_v2;
	assign out_lhs    = 20'(out_dev) * 20'd100;
	assign out_rhs    = 20'(outl_pct_q) * 20'(m2_q);
	assign out_reject = out_lhs > out_rhs;

	assign st_df   = (win_rd_q >= prev_q) ? win_rd_q - prev_q : prev_q - win_rd_q;
	assign st_xsq  = 24'(win_rd_q) * 24'(win_rd_q);
	assign st_dfsq = 24'(st_df) * 24'(st_df);

	assign div_sh   = {div_rem_q, div_num_q[NUMW-1]};
	assign div_sub  = div_sh - {1'b0, div_den_q};
	assign div_ge   = div_sh >= {1'b0, div_den_q};
	assign div_last = (step_q == STW'(NUMW - 1));
	assign sq_sh    = {sq_rem_q[RTW-1:0], sq_op_q[NUMW-1 -: 2]};
	assign sq_trial = {sq_root_q, 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;
	assign sq_last  = (step_q == STW'(RTW - 1));
	assign root_sat = (sq_root_q > RTW'(hrvtd_pkg::METRIC_CAP)) ?
		13'(hrvtd_pkg::METRIC_CAP) : sq_root_q[12:0];

	assign n_m30 = win_cnt_q - WC'(hrvtd_pkg::Q_BEATS_OFFS);
	assign q_a   = (win_cnt_q <= WC'(hrvtd_pkg::Q_BEATS_OFFS)) ? 7'd0 :
		((n_m30 > WC'(hrvtd_pkg::Q_BEATS_CAP)) ? 7'(hrvtd_pkg::Q_BEATS_CAP) : n_m30[6:0]);
	assign upq10 = 14'(upq_q) * 14'd10;
	assign q_b   = (upq10 <= 14'(hrvtd_pkg::Q_UPQ_OFFS)) ? 13'd0 :
		((upq10 - 14'(hrvtd_pkg::Q_UPQ_OFFS) > 14'(hrvtd_pkg::Q_UPQ_CAP)) ?
		13'(hrvtd_pkg::Q_UPQ_CAP) : 13'(upq10 - 14'(hrvtd_pkg::Q_UPQ_OFFS)));
	assign q_c   = (motion_q < 13'(hrvtd_pkg::Q_MOTION_REF)) ?
		12'(13'(hrvtd_pkg::Q_MOTION_REF) - motion_q) : 12'd0;
	assign q_num = 20'({q_a, 12'b0}) + 20'(q_b) * 20'(hrvtd_pkg::Q_W_UPQ) +
		20'(q_c) * 20'(hrvtd_pkg::Q_W_MOTION);

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			hrvtd_pkg::ST_M_NQ: begin
				mul_a = sq_q;
				mul_b = SW'(win_cnt_q);
			end
			hrvtd_pkg::ST_M_SS: begin
				mul_a = QW'(sum_q);
				mul_b = sum_q;
			end
			hrvtd_pkg::ST_M_SUB: begin
				mul_a = QW'(win_cnt_q);
				mul_b = SW'(win_cnt_q - 1'b1);
			end
			hrvtd_pkg::ST_PN_MUL: begin
				mul_a = QW'(nn50_q);
				mul_b = SW'(hrvtd_pkg::PNN_SCALE);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hrvtd_pkg::ST_IDLE: begin
				if (acc_in && !is_beat) begin
					if (req.upstream_idle || (mot_new > mot_lim_q) || (pend_cnt_q == '0))
						state_d = hrvtd_pkg::ST_EMIT;
					else
						state_d = hrvtd_pkg::ST_P_RD;
				end
			end
			hrvtd_pkg::ST_P_RD:   state_d = hrvtd_pkg::ST_P_DATA;
			hrvtd_pkg::ST_P_DATA: begin
				if (!in_range)
					state_d = next_beat_st;
				else if (win_cnt_q > WC'(hrvtd_pkg::OUTLIER_MIN_COUNT))
					state_d = hrvtd_pkg::ST_MED_SCAN;
				else
					state_d = hrvtd_pkg::ST_PUSH;
			end
			hrvtd_pkg::ST_MED_SCAN: if (scan_done) state_d = hrvtd_pkg::ST_MED_STEP;
			hrvtd_pkg::ST_MED_STEP: begin
				if (med_b_q == 4'd0 && med_pass_q)
					state_d = hrvtd_pkg::ST_OUTLIER;
				else
					state_d = hrvtd_pkg::ST_MED_SCAN;
			end
			hrvtd_pkg::ST_OUTLIER:   state_d = out_reject ? next_beat_st : hrvtd_pkg::ST_PUSH;
			hrvtd_pkg::ST_PUSH:      state_d = next_beat_st;
			hrvtd_pkg::ST_CHECK_N:   state_d = short_win ? hrvtd_pkg::ST_EMIT : hrvtd_pkg::ST_STAT_SCAN;
			hrvtd_pkg::ST_STAT_SCAN: if (scan_done) state_d = hrvtd_pkg::ST_M_NQ;
			hrvtd_pkg::ST_M_NQ:      state_d = hrvtd_pkg::ST_M_SS;
			hrvtd_pkg::ST_M_SS:      state_d = hrvtd_pkg::ST_M_SUB;
			hrvtd_pkg::ST_M_SUB:     state_d = hrvtd_pkg::ST_SD_LOAD;
			hrvtd_pkg::ST_SD_LOAD:   state_d = hrvtd_pkg::ST_SD_DIV;
			hrvtd_pkg::ST_SD_DIV:    if (div_last) state_d = hrvtd_pkg::ST_SD_SQL;
			hrvtd_pkg::ST_SD_SQL:    state_d = hrvtd_pkg::ST_SD_SQRT;
			hrvtd_pkg::ST_SD_SQRT:   if (sq_last) state_d = hrvtd_pkg::ST_RM_LOAD;
			hrvtd_pkg::ST_RM_LOAD:   state_d = hrvtd_pkg::ST_RM_DIV;
			hrvtd_pkg::ST_RM_DIV:    if (div_last) state_d = hrvtd_pkg::ST_RM_SQL;
			hrvtd_pkg::ST_RM_SQL:    state_d = hrvtd_pkg::ST_RM_SQRT;
			hrvtd_pkg::ST_RM_SQRT:   if (sq_last) state_d = hrvtd_pkg::ST_PN_MUL;
			hrvtd_pkg::ST_PN_MUL:    state_d = hrvtd_pkg::ST_PN_LOAD;
			hrvtd_pkg::ST_PN_LOAD:   state_d = hrvtd_pkg::ST_PN_DIV;
			hrvtd_pkg::ST_PN_DIV:    if (div_last) state_d = hrvtd_pkg::ST_Q_LOAD;
			hrvtd_pkg::ST_Q_LOAD:    state_d = hrvtd_pkg::ST_Q_DIV;
			hrvtd_pkg::ST_Q_DIV:     if (div_last) state_d = hrvtd_pkg::ST_FINISH;
			hrvtd_pkg::ST_FINISH:    state_d = hrvtd_pkg::ST_EMIT;
			hrvtd_pkg::ST_EMIT:      if (!res_valid_q || !res_stall) state_d = hrvtd_pkg::ST_IDLE;
			default:                 state_d = hrvtd_pkg::ST_IDLE;
		endcase
	end

	assign req_stall = (state_q != hrvtd_pkg::ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hrvtd_pkg::ST_IDLE;
			min_beats_q <= 9'd30;
			int_low_q   <= 12'd300;
			int_high_q  <= 12'd2000;
			outl_pct_q  <= 7'd20;
			succ_lim_q  <= 10'd50;
			mot_lim_q   <= 13'd2048;
			qual_lim_q  <= 11'd512;
			pend_head_q <= '0;
			pend_cnt_q  <= '0;
			win_head_q  <= '0;
			win_cnt_q   <= '0;
			motion_q    <= '0;
			held_q      <= '{status: hrvtd_pkg::STATUS_ACQUIRING, default: '0};
			res_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;

			if (cfg_we) begin
				unique case (cfg_index)
					hrvtd_pkg::CFG_MIN_BEATS:     min_beats_q <= cfg_data[8:0];
					hrvtd_pkg::CFG_INTERVAL_LOW:  int_low_q   <= cfg_data[11:0];
					hrvtd_pkg::CFG_INTERVAL_HIGH: int_high_q  <= cfg_data[11:0];
					hrvtd_pkg::CFG_OUTLIER_PCT:   outl_pct_q  <= cfg_data[6:0];
					hrvtd_pkg::CFG_SUCC_LIMIT:    succ_lim_q  <= cfg_data[9:0];
					hrvtd_pkg::CFG_MOTION_LIMIT:  mot_lim_q   <= cfg_data[12:0];
					hrvtd_pkg::CFG_QUALITY_LIMIT: qual_lim_q  <= cfg_data[10:0];
					default: ;
				endcase
			end

			if (state_q == hrvtd_pkg::ST_IDLE && acc_in) begin
				if (is_beat) begin
					// full queue drops its oldest word
					if (pend_cnt_q == PC'(PENDING_DEPTH))
						pend_head_q <= pend_head_inc;
					else
						pend_cnt_q <= pend_cnt_q + 1'b1;
				end else if (req.upstream_idle) begin
					held_q <= '{status: hrvtd_pkg::STATUS_IDLE, stamp_ms: req.time_ms, default: '0};
				end else begin
					motion_q <= mot_new;
					if (mot_new > mot_lim_q) begin
						held_q.status       <= hrvtd_pkg::STATUS_LOW_QUALITY;
						held_q.result_valid <= 1'b0;
					end
				end
			end

			if (state_q == hrvtd_pkg::ST_P_RD) begin
				pend_head_q <= pend_head_inc;
				pend_cnt_q  <= pend_cnt_q - 1'b1;
			end

			if (state_q == hrvtd_pkg::ST_PUSH) begin
				if (win_cnt_q == WC'(WINDOW_DEPTH))
					win_head_q <= (win_head_q == WA'(WINDOW_DEPTH - 1)) ? '0 : win_head_q + 1'b1;
				else
					win_cnt_q <= win_cnt_q + 1'b1;
			end

			if (state_q == hrvtd_pkg::ST_CHECK_N && short_win)
				held_q <= '{status: hrvtd_pkg::STATUS_ACQUIRING, stamp_ms: stamp_in_q,
					default: '0};

			if (state_q == hrvtd_pkg::ST_FINISH) begin
				held_q.status       <= (div_num_q[10:0] < qual_lim_q) ?
					hrvtd_pkg::STATUS_LOW_QUALITY : hrvtd_pkg::STATUS_VALID;
				held_q.rmssd        <= rm_res_q;
				held_q.sdnn         <= sd_res_q;
				held_q.pnn50        <= pn_res_q;
				held_q.quality      <= div_num_q[10:0];
				held_q.result_valid <= !(div_num_q[10:0] < qual_lim_q);
				held_q.stamp_ms     <= stamp_in_q;
			end

			if (state_q == hrvtd_pkg::ST_EMIT && (!res_valid_q || !res_stall))
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// stores
	always_ff @(posedge clk) begin
		if (state_q == hrvtd_pkg::ST_IDLE && acc_in && is_beat)
			pend_mem[pend_wa] <= req.interval_ms;
		pend_rd_q <= pend_mem[pend_head_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == hrvtd_pkg::ST_PUSH)
			win_mem[push_addr] <= cand_q;
		win_rd_q <= win_mem[scan_addr];
	end

	// datapath
	always_ff @(posedge clk) begin
		mult_q <= mul_a * mul_b;

		if (state_q == hrvtd_pkg::ST_IDLE && acc_in) begin
			upq_q      <= req.upstream_quality;
			stamp_in_q <= req.time_ms;
		end

		if (state_q == hrvtd_pkg::ST_EMIT && (!res_valid_q || !res_stall))
			res_q <= held_q;

		if (scan_issue)
			scan_i_q <= scan_i_q + 1'b1;
		else if (!scan_st)
			scan_i_q <= '0;

		if (state_q != hrvtd_pkg::ST_MED_SCAN)
			med_cnt_q <= '0;
		else if (rd_vld_s1 && win_rd_q <= med_tv)
			med_cnt_q <= med_cnt_q + 1'b1;

		if (state_q == hrvtd_pkg::ST_P_DATA) begin
			cand_q     <= pend_rd_q;
			rank_q     <= (win_cnt_q - 1'b1) >> 1;
			med_r_q    <= '0;
			med_b_q    <= 4'd11;
			med_pass_q <= 1'b0;
		end

		// two rank searches: lower middle then upper middle
		if (state_q == hrvtd_pkg::ST_MED_STEP) begin
			if (med_b_q == 4'd0) begin
				if (!med_pass_q) begin
					med_r1_q   <= med_r_new;
					med_pass_q <= 1'b1;
					rank_q     <= win_cnt_q >> 1;
					med_r_q    <= '0;
					med_b_q    <= 4'd11;
				end else begin
					m2_q <= 13'(med_r1_q) + 13'(med_r_new);
				end
			end else begin
				med_r_q <= med_r_new;
				med_b_q <= med_b_q - 1'b1;
			end
		end

		if (state_q == hrvtd_pkg::ST_CHECK_N) begin
			sum_q   <= '0;
			sq_q    <= '0;
			ssd_q   <= '0;
			nn50_q  <= '0;
			first_q <= 1'b1;
		end else if (state_q == hrvtd_pkg::ST_STAT_SCAN && rd_vld_s1) begin
			sum_q   <= sum_q + SW'(win_rd_q);
			sq_q    <= sq_q + QW'(st_xsq);
			prev_q  <= win_rd_q;
			first_q <= 1'b0;
			if (!first_q) begin
				ssd_q <= ssd_q + QW'(st_dfsq);
				if (st_df > 12'(succ_lim_q))
					nn50_q <= nn50_q + 1'b1;
			end
		end

		if (state_q == hrvtd_pkg::ST_M_SS)
			nq_q <= mult_q;
		if (state_q == hrvtd_pkg::ST_M_SUB)
			nq_q <= nq_q - mult_q;

		unique case (state_q)
			hrvtd_pkg::ST_SD_LOAD: begin
				div_num_q <= {nq_q[WC+QW-1:0], 8'b0};
				div_den_q <= mult_q[DENW-1:0];
				div_rem_q <= '0;
				step_q    <= '0;
			end
			hrvtd_pkg::ST_RM_LOAD: begin
				sd_res_q  <= root_sat;
				div_num_q <= NUMW'({ssd_q, 8'b0});
				div_den_q <= DENW'(win_cnt_q - 1'b1);
				div_rem_q <= '0;
				step_q    <= '0;
			end
			hrvtd_pkg::ST_PN_MUL: rm_res_q <= root_sat;
			hrvtd_pkg::ST_PN_LOAD: begin
				div_num_q <= mult_q[NUMW-1:0];
				div_den_q <= DENW'(win_cnt_q - 1'b1);
				div_rem_q <= '0;
				step_q    <= '0;
			end
			hrvtd_pkg::ST_Q_LOAD: begin
				pn_res_q  <= (div_num_q > NUMW'(hrvtd_pkg::PNN_CAP)) ?
					11'(hrvtd_pkg::PNN_CAP) : div_num_q[10:0];
				div_num_q <= NUMW'(q_num);
				div_den_q <= DENW'(hrvtd_pkg::Q_DIVISOR);
				div_rem_q <= '0;
				step_q    <= '0;
			end
			hrvtd_pkg::ST_SD_DIV, hrvtd_pkg::ST_RM_DIV, hrvtd_pkg::ST_PN_DIV,
			hrvtd_pkg::ST_Q_DIV: begin
				div_rem_q <= div_ge ? div_sub[DENW-1:0] : div_sh[DENW-1:0];
				div_num_q <= {div_num_q[NUMW-2:0], div_ge};
				step_q    <= step_q + 1'b1;
			end
			hrvtd_pkg::ST_SD_SQL, hrvtd_pkg::ST_RM_SQL: begin
				sq_op_q   <= div_num_q;
				sq_root_q <= '0;
				sq_rem_q  <= '0;
				step_q    <= '0;
			end
			hrvtd_pkg::ST_SD_SQRT, hrvtd_pkg::ST_RM_SQRT: begin
				sq_rem_q  <= sq_ge ? sq_sh - sq_trial : sq_sh;
				sq_root_q <= {sq_root_q[RTW-2:0], sq_ge};
				sq_op_q   <= sq_op_q << 2;
				step_q    <= step_q + 1'b1;
			end
			default: ;
		endcase
	end

	a_win_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		win_cnt_q <= WC'(WINDOW_DEPTH))
		else $error("window count beyond depth");

	a_pend_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q <= PC'(PENDING_DEPTH))
		else $error("pending count beyond depth");

	a_beat_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && is_beat && pend_cnt_q < PC'(PENDING_DEPTH)) |=>
		pend_cnt_q == $past(pend_cnt_q) + 1'b1)
		else $error("beat word not queued");

	a_res_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == hrvtd_pkg::ST_EMIT))
		else $error("result word raised outside emit");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ($past(state_q == hrvtd_pkg::ST_MED_SCAN) ||
		$past(state_q == hrvtd_pkg::ST_STAT_SCAN)))
		else $error("window read outside a scan");

endmodule
